[design/rfcmp_pkg.sv]
// ----------------------------------------------------------------------------
// RF command parser package
// Shared character codes, parser phase codes and the per-byte result type.
// ----------------------------------------------------------------------------
package rfcmp_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned HdrLen = 8;
  localparam int unsigned HdrIdxW = $clog2(HdrLen);

  typedef logic [ByteW-1:0] byte_t;

  localparam byte_t CharHash  = 8'h23;
  localparam byte_t CharComma = 8'h2C;
  localparam byte_t CharBang  = 8'h21;
  localparam byte_t CharZero  = 8'h30;
  localparam byte_t CharA     = 8'h41;

  // Header "AB56FE21", first character at index 0.
  localparam byte_t HdrChars [HdrLen] = '{8'h41, 8'h42, 8'h35, 8'h36,
                                          8'h46, 8'h45, 8'h32, 8'h31};

  localparam int unsigned PhaseW = 2;
  localparam logic [PhaseW-1:0] PhHunt  = 2'd0;
  localparam logic [PhaseW-1:0] PhSkip  = 2'd1;
  localparam logic [PhaseW-1:0] PhPower = 2'd2;
  localparam logic [PhaseW-1:0] PhAngle = 2'd3;

  typedef struct packed {
    logic  emit;
    byte_t power;
    byte_t angle;
  } rfcmp_result_t;

  // Ten times the value plus (byte - '0'), wrapping at eight bits.
  function automatic byte_t dec_step(input byte_t acc, input byte_t b);
    byte_t times8;
    byte_t times2;
    begin
      times8 = {acc[ByteW-4:0], 3'b000};
      times2 = {acc[ByteW-2:0], 1'b0};
      return byte_t'(times8 + times2 + b - CharZero);
    end
  endfunction

endpackage

[design/rfcmp_if.sv]
// ----------------------------------------------------------------------------
// RF command parser channels
// Valid/ready channels for received bytes and for parsed commands.
// ----------------------------------------------------------------------------
interface rfcmp_in_if
  import rfcmp_pkg::*;
();
  logic  valid;
  logic  ready;
  byte_t rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface rfcmp_out_if
  import rfcmp_pkg::*;
();
  logic  valid;
  logic  ready;
  byte_t power;
  byte_t angle;

  modport source (output valid, output power, output angle, input ready);
  modport sink   (input valid, input power, input angle, output ready);
endinterface

[design/rfcmp_parser.sv]
// ----------------------------------------------------------------------------
// RF command parser core
// Header hunt, field skip and decimal accumulation; one byte per enabled cycle.
// ----------------------------------------------------------------------------
module rfcmp_parser
  import rfcmp_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  byte_t         rx_byte_i,
  output rfcmp_result_t result_o
);

  logic [PhaseW-1:0]  phase_q, phase_d;
  logic [HdrIdxW-1:0] matched_q, matched_d;
  byte_t              power_q, power_d;
  byte_t              angle_q, angle_d;

  always_comb begin
    phase_d         = phase_q;
    matched_d       = matched_q;
    power_d         = power_q;
    angle_d         = angle_q;
    result_o.emit   = 1'b0;
    result_o.power  = power_q;
    result_o.angle  = angle_q;
    case (phase_q)
      PhHunt: begin
        if (rx_byte_i == HdrChars[matched_q]) begin
          if (matched_q == HdrIdxW'(HdrLen - 1)) begin
            phase_d   = PhSkip;
            matched_d = '0;
          end else begin
            matched_d = matched_q + 1'b1;
          end
        end else begin
          // A stray 'A' may itself open a new header.
          matched_d = (rx_byte_i == CharA) ? HdrIdxW'(1) : '0;
        end
      end
      PhSkip: begin
        if (rx_byte_i == CharHash) begin
          power_d = '0;
          angle_d = '0;
          phase_d = PhPower;
        end
      end
      PhPower: begin
        if (rx_byte_i == CharComma) begin
          phase_d = PhAngle;
        end else begin
          power_d = dec_step(power_q, rx_byte_i);
        end
      end
      PhAngle: begin
        if (rx_byte_i == CharBang) begin
          result_o.emit = 1'b1;
          phase_d       = PhHunt;
          matched_d     = '0;
          power_d       = '0;
          angle_d       = '0;
        end else begin
          angle_d = dec_step(angle_q, rx_byte_i);
        end
      end
      default: begin
        phase_d = PhHunt;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhHunt;
      matched_q <= '0;
      power_q   <= '0;
      angle_q   <= '0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      matched_q <= matched_d;
      power_q   <= power_d;
      angle_q   <= angle_d;
    end
  end

endmodule

[design/rf_command_message_parser.sv]
// ----------------------------------------------------------------------------
// RF command message parser
// The closing '!' is registered in the input register and its result in the
// result register before it is shown. Throughput: one byte per cycle unless
// the result stalls; only the parser's next-state logic lies between the two.
// A stalled result holds the pipeline only when the input register is full.
// Reset clears both registers' valid flags and returns the parser to hunting.
// ----------------------------------------------------------------------------
module rf_command_message_parser
  import rfcmp_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  rfcmp_in_if.sink    in_i,
  rfcmp_out_if.source out_o
);

  logic          in_valid_q;
  byte_t         in_byte_q;
  logic          out_valid_q, out_valid_d;
  byte_t         power_q;
  byte_t         angle_q;
  logic          advance;
  rfcmp_result_t result;

  // The parser stage moves whenever the result register is free or drained.
  assign advance    = !out_valid_q || out_o.ready;
  assign in_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_byte_q <= in_i.rx_byte;
    end
  end

  rfcmp_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (in_valid_q && advance),
    .rx_byte_i (in_byte_q),
    .result_o  (result)
  );

  assign out_valid_d = advance ? (in_valid_q && result.emit) : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_valid_q && result.emit) begin
      power_q <= result.power;
      angle_q <= result.angle;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.power = power_q;
  assign out_o.angle = angle_q;

endmodule

[design/rfcmp_checker.sv]
// ----------------------------------------------------------------------------
// RF command parser port checker
// Watches the top-level channels for handshake and pipeline timing slips.
// ----------------------------------------------------------------------------
module rfcmp_checker
  import rfcmp_pkg::*;
(
  input logic  clk_i,
  input logic  rst_ni,
  input logic  in_valid_i,
  input logic  in_ready_i,
  input logic  out_valid_i,
  input logic  out_ready_i,
  input byte_t power_i,
  input byte_t angle_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result withdrawn while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(power_i) && $stable(angle_i))
    else $error("result payload changed while stalled");

  // A fresh result always comes from an item taken into the input register.
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i, 2))
    else $error("result without a matching input item");

  // Input backpressure only ever comes from a waiting result.
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i)
    else $error("input stalled with no result pending");

endmodule

bind rf_command_message_parser rfcmp_checker u_rfcmp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .power_i     (out_o.power),
  .angle_i     (out_o.angle)
);

[tb/rf_command_message_parser_test.sv]
// ----------------------------------------------------------------------------
// RF command message parser testbench
// Feeds received bytes through the input channel and checks every parsed
// command against an in-bench model of the parser. A short table of directed
// bytes comes first, then random frames under several idling patterns,
// including one long hold-off on the result side.
// ----------------------------------------------------------------------------
module rf_command_message_parser_test;
  import rfcmp_pkg::*;

  typedef struct packed {
    byte_t power;
    byte_t angle;
  } cmd_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  always #6 clk_i = ~clk_i;

  rfcmp_in_if  in_if ();
  rfcmp_out_if out_if ();

  rf_command_message_parser i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Model state of the parser.
  logic [PhaseW-1:0] mdl_phase;
  logic [3:0]        mdl_hdr_pos;
  byte_t             mdl_power;
  byte_t             mdl_angle;

  cmd_t exp_cmd_q [$];

  int unsigned err_cnt;
  int unsigned cmd_cnt;
  int unsigned byte_cnt;

  int unsigned src_idle_pct;
  int unsigned snk_stall_pct;
  bit          hold_req;
  int unsigned hold_left;

  // Directed table: one row per byte, with a typed-in command on some rows.
  byte_t dir_byte  [$];
  bit    dir_typed [$];
  cmd_t  dir_cmd   [$];

  function automatic byte_t dec_accum(input byte_t acc, input byte_t b);
    logic [31:0] v;
    v = 32'(acc) * 32'd10 + 32'(b) - 32'(CharZero);
    return v[7:0];
  endfunction

  function automatic bit parse_byte(input byte_t b, output cmd_t cmd);
    logic [3:0] pos;
    cmd = '0;
    case (mdl_phase)
      PhHunt: begin
        pos = {1'b0, mdl_hdr_pos[2:0]};
        if (b == HdrChars[pos[2:0]]) begin
          pos = pos + 4'd1;
          if (pos >= 4'(HdrLen)) begin
            mdl_phase   = PhSkip;
            mdl_hdr_pos = '0;
          end else begin
            mdl_hdr_pos = pos;
          end
        end else begin
          // A stray 'A' restarts the header match as its first character.
          mdl_hdr_pos = (b == CharA) ? 4'd1 : 4'd0;
        end
      end
      PhSkip: begin
        if (b == CharHash) begin
          mdl_power = '0;
          mdl_angle = '0;
          mdl_phase = PhPower;
        end
      end
      PhPower: begin
        if (b == CharComma) mdl_phase = PhAngle;
        else mdl_power = dec_accum(mdl_power, b);
      end
      default: begin
        if (b == CharBang) begin
          cmd.power   = mdl_power;
          cmd.angle   = mdl_angle;
          mdl_phase   = PhHunt;
          mdl_hdr_pos = '0;
          mdl_power   = '0;
          mdl_angle   = '0;
          return 1'b1;
        end
        mdl_angle = dec_accum(mdl_angle, b);
      end
    endcase
    return 1'b0;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    err_cnt++;
  endtask

  task automatic put_text(input string s, input bit typed, input byte_t pw, input byte_t an);
    for (int i = 0; i < s.len(); i++) begin
      dir_byte.push_back(byte_t'(s[i]));
      dir_typed.push_back(typed && (i == s.len() - 1));
      dir_cmd.push_back({pw, an});
    end
  endtask

  task automatic put_raw(input byte_t b);
    dir_byte.push_back(b);
    dir_typed.push_back(1'b0);
    dir_cmd.push_back('0);
  endtask

  // Offers one item and waits for it to be taken; the expectation is queued
  // on acceptance.
  task automatic send_byte(input byte_t b, input bit typed, input cmd_t typed_cmd);
    cmd_t got;
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.rx_byte <= b;
    do @(posedge clk_i); while (!in_if.ready);
    byte_cnt++;
    if (parse_byte(b, got)) exp_cmd_q.push_back(typed ? typed_cmd : got);
  endtask

  task automatic send_plain(input byte_t b);
    send_byte(b, 1'b0, '0);
  endtask

  // A field of up to four bytes, mostly decimal digits, never the terminator.
  task automatic send_field(input byte_t stop);
    int unsigned n;
    byte_t b;
    n = $urandom_range(0, 4);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 80) b = byte_t'(CharZero + $urandom_range(9));
      else begin
        do b = byte_t'($urandom_range(0, 255)); while (b == stop);
      end
      send_plain(b);
    end
  endtask

  task automatic send_frame(input bit clean);
    int unsigned kind;
    int unsigned n;
    kind = clean ? 99 : $urandom_range(99);
    if (kind < 15) begin
      n = $urandom_range(1, 6);
      repeat (n) send_plain(byte_t'($urandom_range(0, 255)));
    end else if (kind < 27) begin
      // Broken header: a prefix, then a random byte.
      n = $urandom_range(1, HdrLen - 1);
      for (int i = 0; i < n; i++) send_plain(HdrChars[i]);
      send_plain(byte_t'($urandom_range(0, 255)));
    end else begin
      if ($urandom_range(9) == 0) send_plain(CharA);
      for (int i = 0; i < HdrLen; i++) send_plain(HdrChars[i]);
      n = clean ? 0 : $urandom_range(0, 3);
      repeat (n) send_plain(byte_t'($urandom_range(0, 255)));
      send_plain(CharHash);
      send_field(CharComma);
      send_plain(CharComma);
      send_field(CharBang);
      send_plain(CharBang);
    end
  endtask

  task automatic send_until(input int unsigned target);
    while (byte_cnt < target) send_frame(1'b0);
  endtask

  initial begin
    rst_ni        = 1'b0;
    in_if.valid   = 1'b0;
    in_if.rx_byte = '0;
    err_cnt       = 0;
    cmd_cnt       = 0;
    byte_cnt      = 0;
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    hold_req      = 1'b0;
    hold_left     = 0;
    mdl_phase     = PhHunt;
    mdl_hdr_pos   = '0;
    mdl_power     = '0;
    mdl_angle     = '0;

    // Header restart on a stray 'A', empty fields, bytes outside the header
    // at both extremes, and non-digits inside both fields.
    put_raw(8'h00);
    put_text("AAB56FE21#,!", 1'b1, 8'd0, 8'd0);
    put_raw(8'hFF);
    put_text("AB56FE21", 1'b0, '0, '0);
    put_raw(8'hFF);
    put_text("#2#55,9,!", 1'b0, '0, '0);

    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    for (int i = 0; i < dir_byte.size(); i++) send_byte(dir_byte[i], dir_typed[i], dir_cmd[i]);

    send_until(200);

    // Long hold-off on the result side while the frames keep coming.
    hold_req = 1'b1;
    repeat (14) send_frame(1'b1);

    // Each idling phase gets its own share of bytes, whatever the hold-off sent.
    src_idle_pct = 84;
    send_until(byte_cnt + 140);
    src_idle_pct  = 0;
    snk_stall_pct = 84;
    send_until(byte_cnt + 140);
    src_idle_pct  = 24;
    snk_stall_pct = 24;
    send_until(byte_cnt + 140);

    @(negedge clk_i);
    in_if.valid   <= 1'b0;
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    while (exp_cmd_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("Sent %0d bytes (directed table, random frames, noise and broken headers).",
             byte_cnt);
    $display("Checked %0d commands under free flow, source gaps, sink stalls and a hold-off.",
             cmd_cnt);
    if (err_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Result side: ready is driven at the falling edge, items taken at the rising.
  initial begin
    cmd_t want;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 400;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= snk_stall_pct);
      end
      @(posedge clk_i);
      if (out_if.valid && out_if.ready) begin
        cmd_cnt++;
        if (exp_cmd_q.size() == 0) begin
          report_mismatch($sformatf("command power=%0d angle=%0d with none expected",
                                    out_if.power, out_if.angle));
        end else begin
          want = exp_cmd_q.pop_front();
          if (out_if.power !== want.power)
            report_mismatch($sformatf("power %0d, expected %0d", out_if.power, want.power));
          if (out_if.angle !== want.angle)
            report_mismatch($sformatf("angle %0d, expected %0d", out_if.angle, want.angle));
        end
      end
    end
  end

  initial begin
    #2000000;
    $display("Timed out with %0d commands outstanding.", exp_cmd_q.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

[sim.f]
design/rfcmp_pkg.sv
design/rfcmp_if.sv
design/rfcmp_parser.sv
design/rf_command_message_parser.sv
design/rfcmp_checker.sv
tb/rf_command_message_parser_test.sv
